### rtl/tac_pkg.sv
// Shared types and fixed widths for the touch affine calibration block.
`timescale 1ns / 1ps
package tac_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  // accumulator widths sized for up to 64 points
  localparam int CNT_W  = 7;
  localparam int SUM_W  = 18;
  localparam int SQ_W   = 30;

  localparam int SLOPE_W  = 32;
  localparam int OFFSET_W = 44;

  // shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // divider
  localparam int NUM_W  = 50;
  localparam int DEN_W  = 37;
  localparam int REM_W  = DEN_W + 1;
  localparam int QW     = OFFSET_W + 1;
  localparam int DIV_W  = NUM_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [QW:0] CAP_WIDE =
    {{(QW + 1 - OFFSET_W){1'b0}}, 1'b1, {(OFFSET_W - 1){1'b0}}};
  localparam logic [QW:0] CAP_NARROW =
    {{(QW + 1 - SLOPE_W){1'b0}}, 1'b1, {(SLOPE_W - 1){1'b0}}};

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 1'b1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FEW    = 2'd1;
  localparam logic [1:0] ST_SPREAD = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]            operation;
    logic [COORD_BITS-1:0] raw_x;
    logic [COORD_BITS-1:0] raw_y;
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;
  } tac_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] mapped_x;
    logic [COORD_BITS-1:0] mapped_y;
    logic [1:0]            status;
    logic                  calibrated;
  } tac_result_t;

endpackage

### rtl/tac_div.sv
// Bit-serial signed scaled divider with half-away rounding and saturation.
`timescale 1ns / 1ps
module tac_div import tac_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]           den,
  input  logic                       wide,
  output logic                       done,
  output logic signed [OFFSET_W-1:0] quot
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} div_state_t;

  div_state_t        state;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  dvd;
  logic [REM_W-1:0]  rem;
  logic [QW-1:0]     q;
  logic              ovf;
  logic              neg;
  logic              wide_r;
  logic [DEN_W-1:0]  den_r;

  logic [NUM_W-1:0] mag;
  logic [REM_W-1:0] rem_sh;
  logic             ge;
  logic [REM_W-1:0] rem_next;
  logic             rnd;
  logic [QW:0]      qr;
  logic [QW:0]      cap;
  logic             sat;
  logic [QW:0]      m;
  logic [QW:0]      resv;

  assign mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rem_sh   = {rem[REM_W-2:0], dvd[DIV_W-1]};
  assign ge       = rem_sh >= REM_W'(den_r);
  assign rem_next = ge ? rem_sh - REM_W'(den_r) : rem_sh;

  assign rnd  = {rem, 1'b0} >= (REM_W + 1)'(den_r);
  assign qr   = (QW + 1)'(q) + (QW + 1)'(rnd);
  assign cap  = wide_r ? CAP_WIDE : CAP_NARROW;
  assign sat  = ovf || (qr > cap);
  assign m    = sat ? cap : qr;
  assign resv = neg ? -m : ((m == cap) ? cap - 1'b1 : m);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == D_ROUND);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            neg    <= num[NUM_W-1];
            dvd    <= {mag, {FRAC_BITS{1'b0}}};
            rem    <= '0;
            q      <= '0;
            ovf    <= 1'b0;
            wide_r <= wide;
            den_r  <= den;
            cnt    <= DCNT_W'(DIV_W);
            state  <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= rem_next;
          q   <= {q[QW-2:0], ge};
          ovf <= ovf | q[QW-1];
          dvd <= {dvd[DIV_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == DCNT_W'(1)) state <= D_ROUND;
        end
        D_ROUND: begin
          quot  <= resv[OFFSET_W-1:0];
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

### rtl/touch_affine_calibration.sv
// Top level: least-squares touch calibration with a shared multiplier and divider.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------------
//  command  | start, busy, cmd               | transfer when start && !busy
//  result   | done, result                   | one-cycle strobe, no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | transfer when valid && ready
//
// A full solve runs the bit-serial divider (one bit a cycle) twice per axis, for the
// slope and then the offset. One 33x33 multiplier is time-shared by add, solve and map.
// Reset is synchronous; it restores identity, clears sums and restores default limits.
// busy is high while an item is in work; the receiver cannot stall results.
`timescale 1ns / 1ps
module touch_affine_calibration import tac_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tac_item_t             cmd,
  output logic                  done,
  output tac_result_t           result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3, S_ADD4,
    S_SV_M0, S_SV_M1, S_SV_D, S_SV_M2, S_SV_M3, S_SV_M4, S_SV_M5, S_SV_M6,
    S_SV_W1, S_SV_W2, S_MAP0, S_MAP1, S_MAP2, S_MAP3, S_FIN
  } state_t;

  localparam logic signed [SLOPE_W-1:0] SLOPE_ONE = SLOPE_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  state_t state;
  logic   ax;
  tac_item_t item;

  logic [COORD_BITS-1:0] coord_low;
  logic [COORD_BITS-1:0] coord_high;

  logic [CNT_W-1:0] point_count;
  logic [SUM_W-1:0] raw_sum_x, target_sum_x, raw_sum_y, target_sum_y;
  logic [SQ_W-1:0]  raw_square_sum_x, cross_sum_x, raw_square_sum_y, cross_sum_y;

  logic signed [SLOPE_W-1:0]  slope_x, slope_y, fit_slope, tmp_slope;
  logic signed [OFFSET_W-1:0] offset_x, offset_y, tmp_offset;
  logic                       cal_valid;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, t1, vr, diff;
  logic [DEN_W-1:0]         den_r;
  logic signed [NUM_W-1:0]  num_a, num_b;

  logic [COORD_BITS-1:0] mx, my;
  logic [1:0]            status_r;

  logic [SUM_W-1:0] cur_sx, cur_sy;
  logic [SQ_W-1:0]  cur_sxx, cur_sxy;

  logic                       div_start, div_wide, div_done;
  logic signed [NUM_W-1:0]    div_num;
  logic signed [OFFSET_W-1:0] div_quot;

  function automatic logic signed [MUL_W-1:0] ext_u(input logic [SQ_W-1:0] v);
    ext_u = $signed(MUL_W'(v));
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_v(
    input logic signed [PROD_W-1:0] v,
    input logic [COORD_BITS-1:0]    lo,
    input logic [COORD_BITS-1:0]    hi
  );
    if (v < $signed(PROD_W'(lo)))      clamp_v = lo;
    else if (v > $signed(PROD_W'(hi))) clamp_v = hi;
    else                               clamp_v = v[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [PROD_W-1:0] round_q(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mg;
    mg = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    mg = (mg + HALF) >> FRAC_BITS;
    round_q = v[PROD_W-1] ? -$signed(mg) : $signed(mg);
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign cur_sx  = ax ? raw_sum_y : raw_sum_x;
  assign cur_sy  = ax ? target_sum_y : target_sum_x;
  assign cur_sxx = ax ? raw_square_sum_y : raw_square_sum_x;
  assign cur_sxy = ax ? cross_sum_y : cross_sum_x;
  assign diff    = t1 - prod;

  assign div_start = (state == S_SV_M6) || ((state == S_SV_W1) && div_done);
  assign div_wide  = (state == S_SV_W1);
  assign div_num   = (state == S_SV_M6) ? num_a : num_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ADD0:  begin mul_a = ext_u(SQ_W'(item.raw_x)); mul_b = ext_u(SQ_W'(item.raw_x)); end
      S_ADD1:  begin mul_a = ext_u(SQ_W'(item.raw_x)); mul_b = ext_u(SQ_W'(item.target_x)); end
      S_ADD2:  begin mul_a = ext_u(SQ_W'(item.raw_y)); mul_b = ext_u(SQ_W'(item.raw_y)); end
      S_ADD3:  begin mul_a = ext_u(SQ_W'(item.raw_y)); mul_b = ext_u(SQ_W'(item.target_y)); end
      S_SV_M0: begin mul_a = ext_u(SQ_W'(point_count)); mul_b = ext_u(cur_sxx); end
      S_SV_M1: begin mul_a = ext_u(SQ_W'(cur_sx)); mul_b = ext_u(SQ_W'(cur_sx)); end
      S_SV_M2: begin mul_a = ext_u(SQ_W'(point_count)); mul_b = ext_u(cur_sxy); end
      S_SV_M3: begin mul_a = ext_u(SQ_W'(cur_sx)); mul_b = ext_u(SQ_W'(cur_sy)); end
      S_SV_M4: begin mul_a = ext_u(SQ_W'(cur_sy)); mul_b = ext_u(cur_sxx); end
      S_SV_M5: begin mul_a = ext_u(SQ_W'(cur_sx)); mul_b = ext_u(cur_sxy); end
      S_MAP0:  begin mul_a = MUL_W'(slope_x); mul_b = ext_u(SQ_W'(item.raw_x)); end
      S_MAP1:  begin mul_a = MUL_W'(slope_y); mul_b = ext_u(SQ_W'(item.raw_y)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  tac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .wide  (div_wide),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      state            <= S_IDLE;
      ax               <= 1'b0;
      coord_low        <= '0;
      coord_high       <= '1;
      point_count      <= '0;
      raw_sum_x        <= '0;
      target_sum_x     <= '0;
      raw_square_sum_x <= '0;
      cross_sum_x      <= '0;
      raw_sum_y        <= '0;
      target_sum_y     <= '0;
      raw_square_sum_y <= '0;
      cross_sum_y      <= '0;
      slope_x          <= SLOPE_ONE;
      slope_y          <= SLOPE_ONE;
      offset_x         <= '0;
      offset_y         <= '0;
      cal_valid        <= 1'b0;
    end else begin
      done <= (state == S_FIN);

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LOW:  coord_low  <= cfg_data;
          CFG_HIGH: coord_high <= cfg_data;
          default:  coord_low  <= coord_low;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            item     <= cmd;
            mx       <= '0;
            my       <= '0;
            ax       <= 1'b0;
            unique case (cmd.operation)
              OP_ADD: begin
                if (point_count >= CNT_W'(MAX_POINTS)) begin
                  status_r <= ST_FULL;
                  state    <= S_FIN;
                end else begin
                  status_r <= ST_OK;
                  state    <= S_ADD0;
                end
              end
              OP_SOLVE: begin
                slope_x   <= SLOPE_ONE;
                slope_y   <= SLOPE_ONE;
                offset_x  <= '0;
                offset_y  <= '0;
                cal_valid <= 1'b0;
                if (point_count < CNT_W'(2)) begin
                  status_r <= ST_FEW;
                  state    <= S_FIN;
                end else begin
                  status_r <= ST_OK;
                  state    <= S_SV_M0;
                end
              end
              OP_MAP: begin
                status_r <= ST_OK;
                state    <= S_MAP0;
              end
              OP_CLEAR: begin
                slope_x   <= SLOPE_ONE;
                slope_y   <= SLOPE_ONE;
                offset_x  <= '0;
                offset_y  <= '0;
                cal_valid <= 1'b0;
                status_r  <= ST_OK;
                state     <= S_FIN;
              end
              default: begin
                status_r <= ST_OK;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_ADD0: begin
          point_count  <= point_count + 1'b1;
          raw_sum_x    <= raw_sum_x + SUM_W'(item.raw_x);
          target_sum_x <= target_sum_x + SUM_W'(item.target_x);
          raw_sum_y    <= raw_sum_y + SUM_W'(item.raw_y);
          target_sum_y <= target_sum_y + SUM_W'(item.target_y);
          state        <= S_ADD1;
        end
        S_ADD1: begin
          raw_square_sum_x <= raw_square_sum_x + prod[SQ_W-1:0];
          state            <= S_ADD2;
        end
        S_ADD2: begin
          cross_sum_x <= cross_sum_x + prod[SQ_W-1:0];
          state       <= S_ADD3;
        end
        S_ADD3: begin
          raw_square_sum_y <= raw_square_sum_y + prod[SQ_W-1:0];
          state            <= S_ADD4;
        end
        S_ADD4: begin
          cross_sum_y <= cross_sum_y + prod[SQ_W-1:0];
          state       <= S_FIN;
        end
        S_SV_M0: state <= S_SV_M1;
        S_SV_M1: begin
          t1    <= prod;
          state <= S_SV_D;
        end
        S_SV_D: begin
          // denominator must be strictly positive on this axis
          if (diff[PROD_W-1] || (diff == '0)) begin
            status_r <= ST_SPREAD;
            state    <= S_FIN;
          end else begin
            den_r <= diff[DEN_W-1:0];
            state <= S_SV_M2;
          end
        end
        S_SV_M2: state <= S_SV_M3;
        S_SV_M3: begin
          t1    <= prod;
          state <= S_SV_M4;
        end
        S_SV_M4: begin
          num_a <= diff[NUM_W-1:0];
          state <= S_SV_M5;
        end
        S_SV_M5: begin
          t1    <= prod;
          state <= S_SV_M6;
        end
        S_SV_M6: begin
          num_b <= diff[NUM_W-1:0];
          state <= S_SV_W1;
        end
        S_SV_W1: begin
          if (div_done) begin
            fit_slope <= div_quot[SLOPE_W-1:0];
            state     <= S_SV_W2;
          end
        end
        S_SV_W2: begin
          if (div_done) begin
            if (!ax) begin
              // hold the x fit until the y axis also succeeds
              tmp_slope  <= fit_slope;
              tmp_offset <= div_quot;
              ax         <= 1'b1;
              state      <= S_SV_M0;
            end else begin
              slope_x   <= tmp_slope;
              offset_x  <= tmp_offset;
              slope_y   <= fit_slope;
              offset_y  <= div_quot;
              cal_valid <= 1'b1;
              state     <= S_FIN;
            end
          end
        end
        S_MAP0: state <= S_MAP1;
        S_MAP1: begin
          vr    <= prod + PROD_W'(offset_x);
          state <= S_MAP2;
        end
        S_MAP2: begin
          mx    <= cal_valid ? clamp_v(round_q(vr), coord_low, coord_high)
                             : clamp_v($signed(PROD_W'(item.raw_x)), coord_low, coord_high);
          vr    <= prod + PROD_W'(offset_y);
          state <= S_MAP3;
        end
        S_MAP3: begin
          my    <= cal_valid ? clamp_v(round_q(vr), coord_low, coord_high)
                             : clamp_v($signed(PROD_W'(item.raw_y)), coord_low, coord_high);
          state <= S_FIN;
        end
        S_FIN: begin
          if (item.operation == OP_SOLVE) begin
            point_count      <= '0;
            raw_sum_x        <= '0;
            target_sum_x     <= '0;
            raw_square_sum_x <= '0;
            cross_sum_x      <= '0;
            raw_sum_y        <= '0;
            target_sum_y     <= '0;
            raw_square_sum_y <= '0;
            cross_sum_y      <= '0;
          end
          result.mapped_x   <= mx;
          result.mapped_y   <= my;
          result.status     <= status_r;
          result.calibrated <= cal_valid;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_few_uncal: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_FEW) |-> !result.calibrated)
    else $error("failed solve left a calibrated transform");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count passed its cap");
`endif

endmodule
